// ===== design/stbs_pkg.sv =====
package stbs_pkg;

  // Default sizes of the table.
  localparam int TABLE_DEPTH_DEFAULT = 64;
  localparam int KEY_WIDTH_DEFAULT   = 32;

  // Fixed field widths.
  localparam int ACTION_W = 3;
  localparam int STATUS_W = 2;

  // Action codes carried by a command transaction.
  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH       = 3'd0,
    ACT_POP        = 3'd1,
    ACT_INS_AT     = 3'd2,
    ACT_SEARCH     = 3'd3,
    ACT_INS_SORTED = 3'd4
  } action_t;

  // Status codes carried by a result transaction.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_POP_DATA,
    S_PROBE,
    S_CMP,
    S_SRCH_END,
    S_SHIFT,
    S_PLACE,
    S_DONE
  } state_t;

endpackage

// ===== design/stbs_cmd_if.sv =====
interface stbs_cmd_if #(
  parameter int KEY_WIDTH = stbs_pkg::KEY_WIDTH_DEFAULT,
  parameter int CNT_WIDTH = $clog2(stbs_pkg::TABLE_DEPTH_DEFAULT + 1)
);
  logic                          valid;
  logic                          ready;
  logic [stbs_pkg::ACTION_W-1:0] action;
  logic [KEY_WIDTH-1:0]          key;
  logic [CNT_WIDTH-1:0]          position;

  modport source (output valid, output action, output key, output position, input ready);
  modport sink (input valid, input action, input key, input position, output ready);
endinterface

// ===== design/stbs_res_if.sv =====
interface stbs_res_if #(
  parameter int KEY_WIDTH = stbs_pkg::KEY_WIDTH_DEFAULT,
  parameter int CNT_WIDTH = $clog2(stbs_pkg::TABLE_DEPTH_DEFAULT + 1)
);
  logic                          valid;
  logic                          ready;
  logic [stbs_pkg::STATUS_W-1:0] status;
  logic                          found;
  logic [CNT_WIDTH-1:0]          index;
  logic [KEY_WIDTH-1:0]          popped_key;
  logic [CNT_WIDTH-1:0]          count;

  modport source (output valid, output status, output found, output index,
                  output popped_key, output count, input ready);
  modport sink (input valid, input status, input found, input index,
                input popped_key, input count, output ready);
endinterface

// ===== design/stbs_ram.sv =====
module stbs_ram #(
  parameter int WIDTH = stbs_pkg::KEY_WIDTH_DEFAULT,
  parameter int DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/sorted_table_with_binary_search.sv =====
// Table of up to TABLE_DEPTH unsigned keys held in a one-port-read, one-port-write RAM,
// driven by a small sequencer. One command transaction is taken when the sequencer is
// idle, and cmd.ready stays low until the command has finished; a finished result waits
// in an output register, so the next command may be taken before it is collected.
// A search reads and compares one probe at a time; an insert at a position shifts the
// entries at and above that position up one slot and then writes the key there, and a
// sorted insert runs the search first. The shift moves one entry per cycle, one RAM
// read and one RAM write overlapped. The sequencer goes idle as the result loads, and a
// result that is not collected holds the sequencer in its last state. The worst case is
// a sorted insert at index 0 of a table holding TABLE_DEPTH-1 entries.
// No clearing pass runs after reset.
module sorted_table_with_binary_search #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT,
  parameter int KEY_WIDTH   = stbs_pkg::KEY_WIDTH_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  stbs_cmd_if.sink  cmd,
  stbs_res_if.source res
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

  // Control registers.
  stbs_pkg::state_t state, state_next;
  logic [CW-1:0]    count, count_next;
  logic             pend, pend_next;
  logic             out_valid;
  logic             out_load;

  // Working registers of the current command.
  stbs_pkg::action_t act;
  logic [KEY_WIDTH-1:0] key_r;
  logic [CW-1:0]        pos_r;
  logic [CW-1:0]        base, base_next;
  logic [CW-1:0]        span, span_next;
  logic [CW-1:0]        at_r, at_next;
  logic [CW-1:0]        sh_ptr, sh_ptr_next;
  logic [CW-1:0]        place_pos, place_pos_next;
  logic [AW-1:0]        wr_addr_r, wr_addr_next;
  stbs_pkg::status_t    r_status, r_status_next;
  logic                 r_found, r_found_next;
  logic [CW-1:0]        r_index, r_index_next;
  logic [KEY_WIDTH-1:0] r_popped, r_popped_next;

  // Output register.
  stbs_pkg::status_t    o_status;
  logic                 o_found;
  logic [CW-1:0]        o_index;
  logic [KEY_WIDTH-1:0] o_popped;
  logic [CW-1:0]        o_count;

  // RAM port signals.
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [KEY_WIDTH-1:0] ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [KEY_WIDTH-1:0] ram_rdata;

  logic          is_full;
  logic [CW-1:0] mid;
  logic          cmd_take;

  assign is_full  = (count == FULL_COUNT);
  assign mid      = span >> 1;
  assign cmd_take = cmd.valid && (state == stbs_pkg::S_IDLE);

  stbs_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      stbs_pkg::S_IDLE: begin
        if (cmd_take) begin
          state_next = stbs_pkg::S_DISPATCH;
        end
      end
      stbs_pkg::S_DISPATCH: begin
        unique case (act)
          stbs_pkg::ACT_PUSH: begin
            state_next = is_full ? stbs_pkg::S_DONE : stbs_pkg::S_PLACE;
          end
          stbs_pkg::ACT_POP: begin
            state_next = (count == '0) ? stbs_pkg::S_DONE : stbs_pkg::S_POP_DATA;
          end
          stbs_pkg::ACT_INS_AT: begin
            state_next = ((pos_r > count) || is_full) ? stbs_pkg::S_DONE : stbs_pkg::S_SHIFT;
          end
          stbs_pkg::ACT_SEARCH, stbs_pkg::ACT_INS_SORTED: begin
            state_next = stbs_pkg::S_PROBE;
          end
          default: begin
            state_next = stbs_pkg::S_DONE;
          end
        endcase
      end
      stbs_pkg::S_POP_DATA: begin
        state_next = stbs_pkg::S_DONE;
      end
      stbs_pkg::S_PROBE: begin
        state_next = (span == '0) ? stbs_pkg::S_SRCH_END : stbs_pkg::S_CMP;
      end
      stbs_pkg::S_CMP: begin
        state_next = (ram_rdata == key_r) ? stbs_pkg::S_SRCH_END : stbs_pkg::S_PROBE;
      end
      stbs_pkg::S_SRCH_END: begin
        if (act == stbs_pkg::ACT_INS_SORTED && !is_full) begin
          state_next = stbs_pkg::S_SHIFT;
        end else begin
          state_next = stbs_pkg::S_DONE;
        end
      end
      stbs_pkg::S_SHIFT: begin
        if (sh_ptr <= place_pos) begin
          state_next = stbs_pkg::S_PLACE;
        end
      end
      stbs_pkg::S_PLACE: begin
        state_next = stbs_pkg::S_DONE;
      end
      stbs_pkg::S_DONE: begin
        if (!out_valid || res.ready) begin
          state_next = stbs_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = stbs_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath controls, RAM ports and next values of the working registers.
  always_comb begin
    count_next     = count;
    pend_next      = pend;
    base_next      = base;
    span_next      = span;
    at_next        = at_r;
    sh_ptr_next    = sh_ptr;
    place_pos_next = place_pos;
    wr_addr_next   = wr_addr_r;
    r_status_next  = r_status;
    r_found_next   = r_found;
    r_index_next   = r_index;
    r_popped_next  = r_popped;
    ram_we         = 1'b0;
    ram_waddr      = wr_addr_r;
    ram_wdata      = ram_rdata;
    ram_re         = 1'b0;
    ram_raddr      = '0;
    out_load       = 1'b0;
    unique case (state)
      stbs_pkg::S_IDLE: begin
      end
      stbs_pkg::S_DISPATCH: begin
        r_status_next  = stbs_pkg::ST_OK;
        r_found_next   = 1'b0;
        r_index_next   = '0;
        r_popped_next  = '0;
        pend_next      = 1'b0;
        sh_ptr_next    = count;
        base_next      = '0;
        span_next      = count;
        unique case (act)
          stbs_pkg::ACT_PUSH: begin
            r_index_next   = count;
            place_pos_next = count;
            if (is_full) begin
              r_status_next = stbs_pkg::ST_FULL;
            end
          end
          stbs_pkg::ACT_POP: begin
            if (count == '0) begin
              r_status_next = stbs_pkg::ST_EMPTY;
            end else begin
              ram_re     = 1'b1;
              ram_raddr  = AW'(count - 1'b1);
              count_next = count - 1'b1;
            end
          end
          stbs_pkg::ACT_INS_AT: begin
            r_index_next   = pos_r;
            place_pos_next = pos_r;
            if (pos_r > count) begin
              r_status_next = stbs_pkg::ST_BADPOS;
            end else if (is_full) begin
              r_status_next = stbs_pkg::ST_FULL;
            end
          end
          default: begin
          end
        endcase
      end
      stbs_pkg::S_POP_DATA: begin
        r_popped_next = ram_rdata;
      end
      stbs_pkg::S_PROBE: begin
        // An empty subrange ends the search at its base.
        if (span == '0) begin
          r_index_next = base;
          r_found_next = 1'b0;
        end else begin
          at_next   = base + mid;
          ram_re    = 1'b1;
          ram_raddr = AW'(base + mid);
        end
      end
      stbs_pkg::S_CMP: begin
        // Hit, go left, or go right past the probe.
        if (ram_rdata == key_r) begin
          r_index_next = at_r;
          r_found_next = 1'b1;
        end else if (ram_rdata > key_r) begin
          span_next = mid;
        end else begin
          base_next = at_r + 1'b1;
          span_next = span - mid - 1'b1;
        end
      end
      stbs_pkg::S_SRCH_END: begin
        place_pos_next = r_index;
        sh_ptr_next    = count;
        pend_next      = 1'b0;
        if (act == stbs_pkg::ACT_INS_SORTED && is_full) begin
          r_status_next = stbs_pkg::ST_FULL;
        end
      end
      stbs_pkg::S_SHIFT: begin
        // Write the entry read last cycle one slot up, and read the next one below.
        ram_we    = pend;
        ram_waddr = wr_addr_r;
        ram_wdata = ram_rdata;
        if (sh_ptr > place_pos) begin
          ram_re       = 1'b1;
          ram_raddr    = AW'(sh_ptr - 1'b1);
          wr_addr_next = AW'(sh_ptr);
          sh_ptr_next  = sh_ptr - 1'b1;
          pend_next    = 1'b1;
        end else begin
          pend_next = 1'b0;
        end
      end
      stbs_pkg::S_PLACE: begin
        ram_we     = 1'b1;
        ram_waddr  = AW'(place_pos);
        ram_wdata  = key_r;
        count_next = count + 1'b1;
      end
      stbs_pkg::S_DONE: begin
        out_load = !out_valid || res.ready;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= stbs_pkg::S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      act   <= stbs_pkg::action_t'(cmd.action);
      key_r <= cmd.key;
      pos_r <= cmd.position;
    end
    base      <= base_next;
    span      <= span_next;
    at_r      <= at_next;
    sh_ptr    <= sh_ptr_next;
    place_pos <= place_pos_next;
    wr_addr_r <= wr_addr_next;
    r_status  <= r_status_next;
    r_found   <= r_found_next;
    r_index   <= r_index_next;
    r_popped  <= r_popped_next;
    if (out_load) begin
      o_status <= r_status;
      o_found  <= r_found;
      o_index  <= r_index;
      o_popped <= r_popped;
      o_count  <= count;
    end
  end

  assign cmd.ready      = (state == stbs_pkg::S_IDLE);
  assign res.valid      = out_valid;
  assign res.status     = o_status;
  assign res.found      = o_found;
  assign res.index      = o_index;
  assign res.popped_key = o_popped;
  assign res.count      = o_count;

endmodule

// ===== tb/sorted_table_with_binary_search_checker.sv =====
// Watches the command and result channels, keeps its own copy of the table,
// and compares every result transaction with the oldest outstanding prediction.
module sorted_table_with_binary_search_checker
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT,
  parameter int KEY_WIDTH   = KEY_WIDTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  stbs_cmd_if        cmd,
  stbs_res_if        res,
  output int         errors,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CNT_WIDTH = $clog2(TABLE_DEPTH + 1);

  typedef struct packed {
    status_t              status;
    logic                 found;
    logic [CNT_WIDTH-1:0] index;
    logic [KEY_WIDTH-1:0] popped_key;
    logic [CNT_WIDTH-1:0] count;
  } table_result_t;

  // Shadow copy of the table and the results still owed by the block.
  logic [KEY_WIDTH-1:0] keys [TABLE_DEPTH];
  int unsigned          key_count;
  table_result_t        expected_q [$];

  assign pending = expected_q.size();

  task automatic report_mismatch(string msg);
    $display("%0t: mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [KEY_WIDTH-1:0] got,
                             logic [KEY_WIDTH-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  // Halving search: probe the middle of each subrange, keep the half that can hold the key.
  function automatic int unsigned locate_key(logic [KEY_WIDTH-1:0] key, output logic hit);
    int unsigned lo;
    int unsigned span;
    int unsigned mid;
    int unsigned at;
    lo   = 0;
    span = key_count;
    hit  = 1'b0;
    while (span > 0) begin
      mid = span / 2;
      at  = lo + mid;
      if (keys[at] == key) begin
        hit = 1'b1;
        return at;
      end else if (keys[at] > key) begin
        span = mid;
      end else begin
        lo   = at + 1;
        span = span - mid - 1;
      end
    end
    return lo;
  endfunction

  // Moves exactly the entries from pos up to the count one slot up, then writes the key.
  task automatic insert_key(int unsigned pos, logic [KEY_WIDTH-1:0] key);
    int unsigned j;
    for (j = key_count; j > pos; j--) begin
      keys[j] = keys[j-1];
    end
    keys[pos] = key;
    key_count++;
  endtask

  // Applies one command transaction to the shadow table and forms its result.
  task automatic apply_command(logic [ACTION_W-1:0] act, logic [KEY_WIDTH-1:0] key,
                               logic [CNT_WIDTH-1:0] position, output table_result_t r);
    logic        hit;
    int unsigned at;
    r   = '0;
    hit = 1'b0;
    case (act)
      ACT_PUSH: begin
        r.index = CNT_WIDTH'(key_count);
        if (key_count >= TABLE_DEPTH) r.status = ST_FULL;
        else insert_key(key_count, key);
      end
      ACT_POP: begin
        if (key_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          key_count--;
          r.popped_key = keys[key_count];
        end
      end
      ACT_INS_AT: begin
        r.index = position;
        if (position > key_count) r.status = ST_BADPOS;
        else if (key_count >= TABLE_DEPTH) r.status = ST_FULL;
        else insert_key(position, key);
      end
      ACT_SEARCH: begin
        r.index = CNT_WIDTH'(locate_key(key, hit));
        r.found = hit;
      end
      ACT_INS_SORTED: begin
        at      = locate_key(key, hit);
        r.index = CNT_WIDTH'(at);
        r.found = hit;
        if (key_count >= TABLE_DEPTH) r.status = ST_FULL;
        else insert_key(at, key);
      end
      default: begin
      end
    endcase
    r.count = CNT_WIDTH'(key_count);
  endtask

  // Results are checked before the same edge's command is predicted,
  // since a result can never belong to a command accepted on that edge.
  always @(posedge clk) begin
    table_result_t want;
    if (rst) begin
      key_count = 0;
      expected_q.delete();
      errors = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result transaction with no command outstanding");
        end else begin
          want = expected_q.pop_front();
          check_field("status", KEY_WIDTH'(res.status), KEY_WIDTH'(want.status));
          check_field("found", KEY_WIDTH'(res.found), KEY_WIDTH'(want.found));
          check_field("index", KEY_WIDTH'(res.index), KEY_WIDTH'(want.index));
          check_field("popped_key", res.popped_key, want.popped_key);
          check_field("count", KEY_WIDTH'(res.count), KEY_WIDTH'(want.count));
        end
      end
      if (cmd.valid && cmd.ready) begin
        apply_command(cmd.action, cmd.key, cmd.position, want);
        expected_q.push_back(want);
      end
    end
  end

endmodule

// ===== tb/sorted_table_with_binary_search_tb.sv =====
// Drives command transactions into the table, stalls the result side at random,
// and gives the verdict from the checker's error count.
module sorted_table_with_binary_search_tb;
  import stbs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CNT_WIDTH    = $clog2(TABLE_DEPTH_DEFAULT + 1);
  localparam int RANDOM_ITEMS = 950;
  localparam int PHASE_LEN    = 60;
  localparam int CYCLE_LIMIT  = 1_000_000;

  // Action codes the block treats as no operation.
  localparam logic [ACTION_W-1:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE_LAST  = 3'd7;

  typedef enum {PH_SORTED, PH_FILL, PH_MIXED, PH_DRAIN} phase_t;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   cycles;
  bit   cmd_quiet;
  bit   res_quiet;

  stbs_cmd_if cmd_ch ();
  stbs_res_if res_ch ();

  sorted_table_with_binary_search DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  sorted_table_with_binary_search_checker checker_i (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .res     (res_ch),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the whole run.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Idle cycles before a transaction, with occasional stretches of none at all.
  function automatic int draw_gap(inout bit quiet);
    if ($urandom_range(0, 29) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(0, 14);
  endfunction

  // Sends one command transaction and returns on the edge where it is accepted.
  task automatic send_cmd(logic [ACTION_W-1:0] act, logic [KEY_WIDTH_DEFAULT-1:0] key,
                          logic [CNT_WIDTH-1:0] pos);
    int gap;
    gap = draw_gap(cmd_quiet);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid    <= 1'b1;
    cmd_ch.action   <= act;
    cmd_ch.key      <= key;
    cmd_ch.position <= pos;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  // Each phase leans toward growing, shrinking or keeping the table sorted.
  function automatic logic [ACTION_W-1:0] pick_action(phase_t ph);
    int r;
    r = $urandom_range(0, 99);
    case (ph)
      PH_SORTED: begin
        if (r < 50) return ACT_INS_SORTED;
        if (r < 85) return ACT_SEARCH;
        return ACT_POP;
      end
      PH_FILL: begin
        if (r < 30) return ACT_PUSH;
        if (r < 55) return ACT_INS_AT;
        if (r < 80) return ACT_INS_SORTED;
        if (r < 90) return ACT_SEARCH;
        if (r < 97) return ACT_POP;
      end
      PH_DRAIN: begin
        if (r < 70) return ACT_POP;
        if (r < 85) return ACT_SEARCH;
        if (r < 90) return ACT_PUSH;
        if (r < 95) return ACT_INS_AT;
        return ACT_INS_SORTED;
      end
      default: begin
        if (r < 20) return ACT_PUSH;
        if (r < 45) return ACT_POP;
        if (r < 60) return ACT_INS_AT;
        if (r < 80) return ACT_SEARCH;
        if (r < 95) return ACT_INS_SORTED;
      end
    endcase
    return ACTION_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
  endfunction

  // Small keys give duplicates and search hits; the rest cover the full key range.
  function automatic logic [KEY_WIDTH_DEFAULT-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(0, 15);
    if (r < 45) return '0;
    if (r < 50) return '1;
    return $urandom();
  endfunction

  function automatic logic [CNT_WIDTH-1:0] pick_position();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return CNT_WIDTH'($urandom_range(0, TABLE_DEPTH_DEFAULT));
    if (r < 85) return CNT_WIDTH'($urandom_range(0, (1 << CNT_WIDTH) - 1));
    return CNT_WIDTH'($urandom_range(0, 3));
  endfunction

  // Result side: a random stall before each result transaction.
  initial begin
    int gap;
    res_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      gap = draw_gap(res_quiet);
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
    end
  end

  // Command side: directed corner cases, then phased random traffic.
  initial begin
    phase_t ph;
    rst             <= 1'b1;
    cmd_ch.valid    <= 1'b0;
    cmd_ch.action   <= ACT_PUSH;
    cmd_ch.key      <= '0;
    cmd_ch.position <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Empty table, bad positions and an insert into an empty table.
    send_cmd(ACT_POP, 32'h0000_0000, '0);
    send_cmd(ACT_SEARCH, 32'h0000_0005, '0);
    send_cmd(ACT_INS_AT, 32'h0000_0001, 7'd1);
    send_cmd(ACT_INS_AT, 32'hFFFF_FFFF, '1);
    send_cmd(ACT_INS_SORTED, 32'h0000_0064, '0);

    // Key extremes, inserts at the front and at the count, a position past the count.
    send_cmd(ACT_PUSH, 32'h0000_0000, '0);
    send_cmd(ACT_PUSH, 32'hFFFF_FFFF, '0);
    send_cmd(ACT_INS_AT, 32'h8000_0000, 7'd0);
    send_cmd(ACT_INS_AT, 32'h1234_5678, 7'd4);
    send_cmd(ACT_INS_AT, 32'h0000_0002, 7'd6);
    send_cmd(ACT_INS_AT, 32'h0000_0003, 7'd64);

    // Searches that hit and miss, then a sorted insert of a duplicate.
    send_cmd(ACT_SEARCH, 32'hFFFF_FFFF, '0);
    send_cmd(ACT_SEARCH, 32'h0000_0000, '0);
    send_cmd(ACT_SEARCH, 32'h8000_0000, '0);
    send_cmd(ACT_SEARCH, 32'h0000_0007, '0);
    send_cmd(ACT_INS_SORTED, 32'h0000_0000, '0);

    // Unused action codes.
    for (int code = ACT_SPARE_FIRST; code <= ACT_SPARE_LAST; code++) begin
      send_cmd(ACTION_W'(code), 32'hA5A5_A5A5, '1);
    end

    send_cmd(ACT_POP, '0, '0);
    send_cmd(ACT_POP, '0, '0);
    send_cmd(ACT_POP, '0, '0);
    send_cmd(ACT_PUSH, 32'h5A5A_5A5A, '0);

    // Phased random traffic, drained once in a while so the table hits both ends.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      ph = phase_t'((i / PHASE_LEN) % 4);
      send_cmd(pick_action(ph), pick_key(), pick_position());
    end
    cmd_ch.valid <= 1'b0;

    // Wait for every result, then keep watching for stray results before the verdict.
    do @(negedge clk); while (pending != 0);
    repeat (TABLE_DEPTH_DEFAULT + 8) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
